// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition implies consequence in the same cycle
`define SWZ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swizzle assertion failed");

// condition implies consequence in the next cycle
`define SWZ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swizzle assertion failed");

`endif

// ===== design/swz_pkg.sv =====
`timescale 1ns / 1ps
package swz_pkg;

  localparam int MAX_DIM    = 4096;
  localparam int FRAC_BITS  = 16;
  localparam int DIM_W      = 13;
  localparam int IDX_W      = 12;
  localparam int ACC_W      = 32;
  localparam int STEP_W     = 29;
  localparam int OFF_W      = 26;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int TGT_W      = ACC_W - FRAC_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_WIDTH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HEIGHT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y        = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HAS_ALPHA     = 3'd6;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;

  // clamped configuration as seen by the datapath
  typedef struct packed {
    logic [IDX_W-1:0]  src_w_m1;
    logic [IDX_W-1:0]  src_h_m1;
    logic [DIM_W-1:0]  out_w;
    logic [DIM_W-1:0]  out_h;
    logic [IDX_W-1:0]  out_w_m1;
    logic [IDX_W-1:0]  out_h_m1;
    logic [STEP_W-1:0] step_x;
    logic [STEP_W-1:0] step_y;
    logic              has_alpha;
  } cfg_t;

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [STEP_W-1:0] b);
    logic [ACC_W:0] s;
    begin
      s = {1'b0, a} + {{(ACC_W+1-STEP_W){1'b0}}, b};
      sat_add = s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
    end
  endfunction

  // 4x4 tiles, two bytes per pixel in each half of the tile
  function automatic logic [OFF_W-1:0] tile_offset(input logic [IDX_W-1:0] x,
                                                   input logic [IDX_W-1:0] y,
                                                   input logic [DIM_W-1:0] w);
    logic [20:0] blk;
    logic [26:0] off;
    begin
      blk = 21'(y[IDX_W-1:2] * w[DIM_W-1:2]) + 21'(x[IDX_W-1:2]);
      off = {blk, 1'b0, y[1:0], x[1:0], 1'b0};
      tile_offset = off[OFF_W-1:0];
    end
  endfunction

endpackage

// ===== design/swz_pix_if.sv =====
`timescale 1ns / 1ps
interface swz_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

// ===== design/swz_res_if.sv =====
`timescale 1ns / 1ps
interface swz_res_if;
  logic                     valid;
  logic                     ready;
  logic [swz_pkg::OFF_W-1:0] byte_offset;
  logic [7:0]               out_alpha;
  logic [7:0]               out_red;
  logic [7:0]               out_green;
  logic [7:0]               out_blue;
  logic                     frame_done;

  modport source (output valid, byte_offset, out_alpha, out_red, out_green, out_blue,
                  frame_done, input ready);
  modport sink (input valid, byte_offset, out_alpha, out_red, out_green, out_blue,
                frame_done, output ready);
endinterface

// ===== design/swz_cfg_if.sv =====
`timescale 1ns / 1ps
interface swz_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [swz_pkg::CFG_IDX_W-1:0]  index;
  logic [swz_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/swz_cfg_regs.sv =====
`timescale 1ns / 1ps
module swz_cfg_regs (
  input  logic          clk,
  input  logic          rst_n,
  swz_cfg_if.sink       cfg_wr,
  output swz_pkg::cfg_t cfg
);

  swz_pkg::cfg_t cfg_r;
  swz_pkg::cfg_t cfg_nxt;
  logic [swz_pkg::DIM_W-1:0] wr_dim;

  // source size minus one, zero acts as one, large values clamp
  function automatic logic [swz_pkg::IDX_W-1:0] src_m1(input logic [swz_pkg::DIM_W-1:0] v);
    logic [swz_pkg::DIM_W-1:0] d;
    begin
      d = v - 13'd1;
      if (v == '0) begin
        src_m1 = '0;
      end else if (v > 13'(swz_pkg::MAX_DIM)) begin
        src_m1 = {swz_pkg::IDX_W{1'b1}};
      end else begin
        src_m1 = d[swz_pkg::IDX_W-1:0];
      end
    end
  endfunction

  function automatic logic [swz_pkg::DIM_W-1:0] out_clamp(input logic [swz_pkg::DIM_W-1:0] v);
    logic [swz_pkg::DIM_W-1:0] c;
    begin
      c = (v > 13'(swz_pkg::MAX_DIM)) ? 13'(swz_pkg::MAX_DIM) : v;
      out_clamp = {c[swz_pkg::DIM_W-1:2], 2'b00};
    end
  endfunction

  function automatic logic [swz_pkg::IDX_W-1:0] out_m1(input logic [swz_pkg::DIM_W-1:0] v);
    logic [swz_pkg::DIM_W-1:0] d;
    begin
      d = out_clamp(v) - 13'd1;
      out_m1 = d[swz_pkg::IDX_W-1:0];
    end
  endfunction

  assign cfg_wr.ready = 1'b1;
  assign wr_dim       = cfg_wr.data[swz_pkg::DIM_W-1:0];
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr.valid) begin
      case (cfg_wr.index)
        swz_pkg::REG_SOURCE_WIDTH:  cfg_nxt.src_w_m1 = src_m1(wr_dim);
        swz_pkg::REG_SOURCE_HEIGHT: cfg_nxt.src_h_m1 = src_m1(wr_dim);
        swz_pkg::REG_OUT_WIDTH: begin
          cfg_nxt.out_w    = out_clamp(wr_dim);
          cfg_nxt.out_w_m1 = out_m1(wr_dim);
        end
        swz_pkg::REG_OUT_HEIGHT: begin
          cfg_nxt.out_h    = out_clamp(wr_dim);
          cfg_nxt.out_h_m1 = out_m1(wr_dim);
        end
        swz_pkg::REG_STEP_X:    cfg_nxt.step_x    = cfg_wr.data[swz_pkg::STEP_W-1:0];
        swz_pkg::REG_STEP_Y:    cfg_nxt.step_y    = cfg_wr.data[swz_pkg::STEP_W-1:0];
        swz_pkg::REG_HAS_ALPHA: cfg_nxt.has_alpha = cfg_wr.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.src_w_m1  <= '0;
      cfg_r.src_h_m1  <= '0;
      cfg_r.out_w     <= '0;
      cfg_r.out_h     <= '0;
      cfg_r.out_w_m1  <= {swz_pkg::IDX_W{1'b1}};
      cfg_r.out_h_m1  <= {swz_pkg::IDX_W{1'b1}};
      cfg_r.step_x    <= swz_pkg::STEP_W'(1 << swz_pkg::FRAC_BITS);
      cfg_r.step_y    <= swz_pkg::STEP_W'(1 << swz_pkg::FRAC_BITS);
      cfg_r.has_alpha <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ===== design/rgba8_tile_swizzle_downscale_unit.sv =====
`timescale 1ns / 1ps
// Nearest-neighbour downscaler feeding a 4x4-tiled RGBA8 texture writer.
// in_pix takes decoded source pixels in raster order, one per cycle when
// ready is high. Each pixel that lands on a destination position inside the
// output size produces one item on out_pix: its tiled byte offset, the A, R,
// G, B bytes and a frame_done flag on the last destination pixel. Other
// pixels only advance the row and column counters and produce nothing.
// cfg_wr writes the seven control registers by index, one per cycle, always
// ready; write them only while no item is in flight.
// A result shows on out_pix in the cycle after its pixel is taken. Throughput is
// one pixel per cycle, set by the single result register; a new pixel is taken
// whenever that register is empty or being drained in the same cycle.
// When the receiver stalls with a result held, in_pix.ready drops and both
// the held result and the counters stay put until it is taken.
// Reset (rst_n low at a clock edge) clears the counters and accumulators,
// empties the result register and restores the register defaults: source
// 1x1, output 0x0, unit steps, alpha forced opaque.
`include "assert_macros.svh"
module rgba8_tile_swizzle_downscale_unit (
  input  logic       clk,
  input  logic       rst_n,
  swz_pix_if.sink    in_pix,
  swz_res_if.source  out_pix,
  swz_cfg_if.sink    cfg_wr
);

  swz_pkg::cfg_t cfg;

  logic [swz_pkg::IDX_W-1:0] src_col_r, src_col_nxt;
  logic [swz_pkg::IDX_W-1:0] src_row_r, src_row_nxt;
  logic [swz_pkg::DIM_W-1:0] dst_col_r, dst_col_nxt;
  logic [swz_pkg::DIM_W-1:0] dst_row_r, dst_row_nxt;
  logic [swz_pkg::ACC_W-1:0] col_acc_r, col_acc_nxt;
  logic [swz_pkg::ACC_W-1:0] row_acc_r, row_acc_nxt;

  logic                      out_valid_r;
  logic [swz_pkg::OFF_W-1:0] out_offset_r;
  logic [7:0]                out_alpha_r, out_red_r, out_green_r, out_blue_r;
  logic                      out_done_r;

  logic in_fire;
  logic row_sel, col_sel, emit;
  logic row_end, frame_end;
  logic last_pix;

  swz_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_wr (cfg_wr),
    .cfg    (cfg)
  );

  assign in_pix.ready = !out_valid_r || out_pix.ready;
  assign in_fire      = in_pix.valid && in_pix.ready;

  assign row_sel = (dst_row_r < cfg.out_h) &&
                   (row_acc_r[swz_pkg::ACC_W-1:swz_pkg::FRAC_BITS] ==
                    swz_pkg::TGT_W'(src_row_r));
  assign col_sel = (dst_col_r < cfg.out_w) &&
                   (col_acc_r[swz_pkg::ACC_W-1:swz_pkg::FRAC_BITS] ==
                    swz_pkg::TGT_W'(src_col_r));
  assign emit      = row_sel && col_sel;
  assign row_end   = src_col_r >= cfg.src_w_m1;
  assign frame_end = row_end && (src_row_r >= cfg.src_h_m1);
  assign last_pix  = (dst_col_r == {1'b0, cfg.out_w_m1}) &&
                     (dst_row_r == {1'b0, cfg.out_h_m1});

  always_comb begin
    src_col_nxt = src_col_r;
    src_row_nxt = src_row_r;
    dst_col_nxt = dst_col_r;
    dst_row_nxt = dst_row_r;
    col_acc_nxt = col_acc_r;
    row_acc_nxt = row_acc_r;
    if (in_fire) begin
      if (col_sel) begin
        dst_col_nxt = dst_col_r + 13'd1;
        col_acc_nxt = swz_pkg::sat_add(col_acc_r, cfg.step_x);
      end
      if (row_end) begin
        src_col_nxt = '0;
        dst_col_nxt = '0;
        col_acc_nxt = '0;
        if (frame_end) begin
          src_row_nxt = '0;
          dst_row_nxt = '0;
          row_acc_nxt = '0;
        end else begin
          src_row_nxt = src_row_r + 12'd1;
          // row selection only moves the destination row once the row is done
          if (row_sel) begin
            dst_row_nxt = dst_row_r + 13'd1;
            row_acc_nxt = swz_pkg::sat_add(row_acc_r, cfg.step_y);
          end
        end
      end else begin
        src_col_nxt = src_col_r + 12'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_col_r   <= '0;
      src_row_r   <= '0;
      dst_col_r   <= '0;
      dst_row_r   <= '0;
      col_acc_r   <= '0;
      row_acc_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      src_col_r <= src_col_nxt;
      src_row_r <= src_row_nxt;
      dst_col_r <= dst_col_nxt;
      dst_row_r <= dst_row_nxt;
      col_acc_r <= col_acc_nxt;
      row_acc_r <= row_acc_nxt;
      if (in_fire) begin
        out_valid_r <= emit;
      end else if (out_pix.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      out_offset_r <= swz_pkg::tile_offset(dst_col_r[swz_pkg::IDX_W-1:0],
                                           dst_row_r[swz_pkg::IDX_W-1:0], cfg.out_w);
      out_alpha_r  <= cfg.has_alpha ? in_pix.alpha : swz_pkg::ALPHA_OPAQUE;
      out_red_r    <= in_pix.red;
      out_green_r  <= in_pix.green;
      out_blue_r   <= in_pix.blue;
      out_done_r   <= last_pix;
    end
  end

  assign out_pix.valid       = out_valid_r;
  assign out_pix.byte_offset = out_offset_r;
  assign out_pix.out_alpha   = out_alpha_r;
  assign out_pix.out_red     = out_red_r;
  assign out_pix.out_green   = out_green_r;
  assign out_pix.out_blue    = out_blue_r;
  assign out_pix.frame_done  = out_done_r;

  `SWZ_ASSERT_NXT(a_emit_shows, in_fire && emit, out_valid_r)
  `SWZ_ASSERT_NXT(a_frame_wrap, in_fire && frame_end,
                  src_col_r == '0 && src_row_r == '0 && dst_row_r == '0 && row_acc_r == '0)
  `SWZ_ASSERT_NXT(a_counters_hold, !in_fire,
                  $stable(src_col_r) && $stable(src_row_r) && $stable(dst_col_r))

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned RANDOM_PIXELS = 850;
  localparam int unsigned QUIET_TAIL    = 250;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned LONG_ROW      = 400;
  localparam int unsigned TALL_ROWS     = 200;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned UNIT_STEP     = 1 << swz_pkg::FRAC_BITS;
  localparam logic [swz_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pixel_t;

  typedef struct packed {
    logic [swz_pkg::OFF_W-1:0] byte_offset;
    logic [7:0]                alpha;
    logic [7:0]                red;
    logic [7:0]                green;
    logic [7:0]                blue;
    logic                      frame_done;
  } texel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #1 clk = ~clk;

  swz_pix_if pix_bus();
  swz_res_if res_bus();
  swz_cfg_if cfg_bus();

  rgba8_tile_swizzle_downscale_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_pix (pix_bus),
    .out_pix(res_bus),
    .cfg_wr (cfg_bus)
  );

  // shadow of the control registers, as written
  logic [swz_pkg::DIM_W-1:0]  src_w_reg;
  logic [swz_pkg::DIM_W-1:0]  src_h_reg;
  logic [swz_pkg::DIM_W-1:0]  out_w_reg;
  logic [swz_pkg::DIM_W-1:0]  out_h_reg;
  logic [swz_pkg::STEP_W-1:0] step_x_reg;
  logic [swz_pkg::STEP_W-1:0] step_y_reg;
  logic                       alpha_reg;

  // scaler position
  logic [swz_pkg::IDX_W-1:0] src_col;
  logic [swz_pkg::IDX_W-1:0] src_row;
  logic [swz_pkg::DIM_W-1:0] dst_col;
  logic [swz_pkg::DIM_W-1:0] dst_row;
  logic [swz_pkg::ACC_W-1:0] col_acc;
  logic [swz_pkg::ACC_W-1:0] row_acc;

  pixel_t pending_pixels[$];
  texel_t expected_texels[$];

  int unsigned pixels_queued = 0;
  int unsigned pixels_taken = 0;
  int unsigned texels_checked = 0;
  int unsigned frame_ends = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  logic no_idle = 1'b0;
  logic long_hold_req = 1'b0;
  logic long_hold_done = 1'b0;
  int unsigned send_gap = 0;
  int unsigned recv_hold = 0;

  pixel_t sb_pixel;
  texel_t sb_texel;
  pixel_t drv_pixel;

  function automatic int unsigned src_clamp(logic [swz_pkg::DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > swz_pkg::MAX_DIM) return swz_pkg::MAX_DIM;
    return 32'(v);
  endfunction

  function automatic int unsigned out_clamp(logic [swz_pkg::DIM_W-1:0] v);
    int unsigned c;
    c = (v > swz_pkg::MAX_DIM) ? swz_pkg::MAX_DIM : 32'(v);
    return c & ~32'd3;
  endfunction

  function automatic logic [swz_pkg::ACC_W-1:0] acc_step(logic [swz_pkg::ACC_W-1:0] acc,
                                                         logic [swz_pkg::STEP_W-1:0] step);
    logic [swz_pkg::ACC_W:0] sum;
    sum = {1'b0, acc} + {{(swz_pkg::ACC_W+1-swz_pkg::STEP_W){1'b0}}, step};
    return sum[swz_pkg::ACC_W] ? {swz_pkg::ACC_W{1'b1}} : sum[swz_pkg::ACC_W-1:0];
  endfunction

  // 4x4 tiles: 32 bytes of A/R then 32 bytes of G/B per tile
  function automatic logic [swz_pkg::OFF_W-1:0] swizzle_offset(int unsigned x, int unsigned y,
                                                               int unsigned w);
    int unsigned tile;
    int unsigned off;
    tile = (y >> 2) * (w >> 2) + (x >> 2);
    off = ((tile << 5) + ((y & 3) << 2) + (x & 3)) << 1;
    return off[swz_pkg::OFF_W-1:0];
  endfunction

  task automatic scale_pixel(input pixel_t px);
    int unsigned sw, sh, ow, oh, col_tgt, row_tgt;
    logic row_hit, col_hit;
    texel_t t;
    sw = src_clamp(src_w_reg);
    sh = src_clamp(src_h_reg);
    ow = out_clamp(out_w_reg);
    oh = out_clamp(out_h_reg);
    col_tgt = col_acc >> swz_pkg::FRAC_BITS;
    row_tgt = row_acc >> swz_pkg::FRAC_BITS;
    row_hit = (dst_row < oh) && (src_row == row_tgt);
    col_hit = (dst_col < ow) && (src_col == col_tgt);
    if (row_hit && col_hit) begin
      t.byte_offset = swizzle_offset(32'(dst_col), 32'(dst_row), ow);
      t.alpha = alpha_reg ? px.alpha : swz_pkg::ALPHA_OPAQUE;
      t.red = px.red;
      t.green = px.green;
      t.blue = px.blue;
      t.frame_done = (dst_col == ow - 1) && (dst_row == oh - 1);
      expected_texels.push_back(t);
    end
    if (col_hit) begin
      dst_col = dst_col + 13'd1;
      col_acc = acc_step(col_acc, step_x_reg);
    end
    if (src_col >= sw - 1) begin
      src_col = '0;
      dst_col = '0;
      col_acc = '0;
      if (src_row >= sh - 1) begin
        src_row = '0;
        dst_row = '0;
        row_acc = '0;
      end else begin
        src_row = src_row + 12'd1;
        if (row_hit) begin
          dst_row = dst_row + 13'd1;
          row_acc = acc_step(row_acc, step_y_reg);
        end
      end
    end else begin
      src_col = src_col + 12'd1;
    end
  endtask

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      pix_bus.valid <= 1'b0;
      send_gap <= 0;
    end else if (!pix_bus.valid || pix_bus.ready) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        pix_bus.valid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 15);
        pix_bus.valid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        drv_pixel = pending_pixels.pop_front();
        pix_bus.valid <= 1'b1;
        pix_bus.red <= drv_pixel.red;
        pix_bus.green <= drv_pixel.green;
        pix_bus.blue <= drv_pixel.blue;
        pix_bus.alpha <= drv_pixel.alpha;
      end else begin
        pix_bus.valid <= 1'b0;
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      res_bus.ready <= 1'b0;
      recv_hold <= 0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      recv_hold <= LONG_HOLD;
      res_bus.ready <= 1'b0;
    end else if (recv_hold != 0) begin
      recv_hold <= recv_hold - 1;
      res_bus.ready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 7) == 0) begin
      recv_hold <= $urandom_range(0, 15);
      res_bus.ready <= 1'b0;
    end else begin
      res_bus.ready <= 1'b1;
    end
  end

  // predict on accepted pixels, then check accepted texels
  always @(posedge clk) begin
    if (rst_n) begin
      if (pix_bus.valid && pix_bus.ready) begin
        sb_pixel.red = pix_bus.red;
        sb_pixel.green = pix_bus.green;
        sb_pixel.blue = pix_bus.blue;
        sb_pixel.alpha = pix_bus.alpha;
        scale_pixel(sb_pixel);
        pixels_taken++;
      end
      if (res_bus.valid && res_bus.ready) begin
        if (expected_texels.size() == 0) begin
          $error("texel at offset %0h with nothing expected", res_bus.byte_offset);
          mismatches++;
        end else begin
          sb_texel = expected_texels.pop_front();
          check_field("byte_offset", 32'(sb_texel.byte_offset), 32'(res_bus.byte_offset));
          check_field("out_alpha", 32'(sb_texel.alpha), 32'(res_bus.out_alpha));
          check_field("out_red", 32'(sb_texel.red), 32'(res_bus.out_red));
          check_field("out_green", 32'(sb_texel.green), 32'(res_bus.out_green));
          check_field("out_blue", 32'(sb_texel.blue), 32'(res_bus.out_blue));
          check_field("frame_done", 32'(sb_texel.frame_done), 32'(res_bus.frame_done));
          texels_checked++;
          if (res_bus.frame_done) frame_ends++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic wait_idle();
    while (pixels_taken != pixels_queued || expected_texels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [swz_pkg::CFG_IDX_W-1:0] idx,
                           input logic [swz_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      swz_pkg::REG_SOURCE_WIDTH:  src_w_reg = data[swz_pkg::DIM_W-1:0];
      swz_pkg::REG_SOURCE_HEIGHT: src_h_reg = data[swz_pkg::DIM_W-1:0];
      swz_pkg::REG_OUT_WIDTH:     out_w_reg = data[swz_pkg::DIM_W-1:0];
      swz_pkg::REG_OUT_HEIGHT:    out_h_reg = data[swz_pkg::DIM_W-1:0];
      swz_pkg::REG_STEP_X:        step_x_reg = data[swz_pkg::STEP_W-1:0];
      swz_pkg::REG_STEP_Y:        step_y_reg = data[swz_pkg::STEP_W-1:0];
      swz_pkg::REG_HAS_ALPHA:     alpha_reg = data[0];
      default: ;
    endcase
    cfg_bus.valid <= 1'b0;
    reg_writes++;
  endtask

  // sometimes set bits above the register width, which must be dropped
  function automatic logic [31:0] with_junk(logic [31:0] v, int unsigned w);
    logic [31:0] junk;
    junk = $urandom;
    if ($urandom_range(0, 3) != 0) return v;
    return v | (junk << w);
  endfunction

  task automatic program_geometry(input int unsigned sw, input int unsigned sh,
                                  input int unsigned ow, input int unsigned oh,
                                  input int unsigned sx, input int unsigned sy,
                                  input int unsigned alpha);
    wait_idle();
    write_reg(swz_pkg::REG_SOURCE_WIDTH, with_junk(sw, swz_pkg::DIM_W));
    write_reg(swz_pkg::REG_SOURCE_HEIGHT, with_junk(sh, swz_pkg::DIM_W));
    write_reg(swz_pkg::REG_OUT_WIDTH, with_junk(ow, swz_pkg::DIM_W));
    write_reg(swz_pkg::REG_OUT_HEIGHT, with_junk(oh, swz_pkg::DIM_W));
    write_reg(swz_pkg::REG_STEP_X, with_junk(sx, swz_pkg::STEP_W));
    write_reg(swz_pkg::REG_STEP_Y, with_junk(sy, swz_pkg::STEP_W));
    write_reg(swz_pkg::REG_HAS_ALPHA, with_junk(alpha, 1));
    if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, $urandom);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic [7:0] a);
    pixel_t px;
    px.red = r;
    px.green = g;
    px.blue = b;
    px.alpha = a;
    pending_pixels.push_back(px);
    pixels_queued++;
  endtask

  task automatic push_random(input int unsigned count);
    repeat (count) push_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // finish the frame in progress, then whole frames, then a ragged tail
  task automatic push_frames(input int unsigned frames, input int unsigned tail,
                             output int unsigned count);
    int unsigned sw, sh, cols_left, rows_after;
    sw = src_clamp(src_w_reg);
    sh = src_clamp(src_h_reg);
    cols_left = (src_col >= sw - 1) ? 1 : sw - src_col;
    rows_after = (src_row >= sh - 1) ? 0 : sh - 1 - src_row;
    count = cols_left + rows_after * sw + frames * sw * sh + tail;
    push_random(count);
  endtask

  function automatic logic [7:0] pattern_byte(int unsigned k);
    case (k % 4)
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'hAA;
      default: return 8'h55;
    endcase
  endfunction

  function automatic int unsigned pick_step();
    case ($urandom_range(0, 9))
      0, 1, 2: return UNIT_STEP;
      3: return 2 * UNIT_STEP;
      4: return $urandom_range(UNIT_STEP, 4 * UNIT_STEP);
      5: return $urandom_range(UNIT_STEP, 3 * UNIT_STEP / 2);
      6: return $urandom_range(0, UNIT_STEP - 1);
      7: return 0;
      8: return 32'h1000_0000;
      default: return 32'h1FFF_FFFF;
    endcase
  endfunction

  initial begin
    int unsigned i, count, random_count, sw, sh, ow, oh, tail;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data = '0;
    src_w_reg = 13'd1;
    src_h_reg = 13'd1;
    out_w_reg = '0;
    out_h_reg = '0;
    step_x_reg = swz_pkg::STEP_W'(UNIT_STEP);
    step_y_reg = swz_pkg::STEP_W'(UNIT_STEP);
    alpha_reg = 1'b0;
    src_col = '0;
    src_row = '0;
    dst_col = '0;
    dst_row = '0;
    col_acc = '0;
    row_acc = '0;
    random_count = 0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // one 4x4 frame with byte extremes, ends on frame_done
    program_geometry(4, 4, 4, 4, UNIT_STEP, UNIT_STEP, 1);
    for (i = 0; i < 16; i++) begin
      push_pixel(pattern_byte(i), pattern_byte(i + 1), pattern_byte(i + 2), pattern_byte(i + 3));
    end
    // alpha forced opaque
    program_geometry(4, 4, 4, 4, UNIT_STEP, UNIT_STEP, 0);
    for (i = 0; i < 4; i++) begin
      push_pixel(pattern_byte(i + 1), pattern_byte(i), pattern_byte(i + 3), 8'h00);
    end
    // zero output width: nothing comes out
    program_geometry(4, 4, 0, 4, UNIT_STEP, UNIT_STEP, 1);
    push_random(4);

    // clamped sizes on a long row; receiver holds off while this streams
    program_geometry(8191, 0, 8191, 8191, UNIT_STEP, UNIT_STEP, 1);
    long_hold_req <= 1'b1;
    push_random(LONG_ROW);
    // tall column at the full output pitch, stopped part way down
    program_geometry(1, swz_pkg::MAX_DIM, swz_pkg::MAX_DIM, swz_pkg::MAX_DIM,
                     UNIT_STEP, UNIT_STEP, 0);
    push_random(TALL_ROWS);

    while (random_count < RANDOM_PIXELS) begin
      if (random_count + QUIET_TAIL >= RANDOM_PIXELS) no_idle <= 1'b1;
      case ($urandom_range(0, 9))
        0: sw = 0;
        1: sw = 16;
        default: sw = $urandom_range(1, 12);
      endcase
      sh = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
      ow = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 18);
      oh = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 12);
      program_geometry(sw, sh, ow, oh, pick_step(), pick_step(), $urandom_range(0, 1));
      tail = 0;
      if ($urandom_range(0, 3) == 0) begin
        tail = $urandom_range(1, src_clamp(13'(sw)) * src_clamp(13'(sh)));
      end
      push_frames($urandom_range(1, 3), tail, count);
      random_count += count;
    end

    wait_idle();
    $display("pixels in %0d, texels checked %0d, frame ends %0d, register writes %0d",
             pixels_taken, texels_checked, frame_ends, reg_writes);
    $display("covered clamped sizes, fractional and huge steps, oversized and empty outputs");
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/swz_pkg.sv
design/swz_pix_if.sv
design/swz_res_if.sv
design/swz_cfg_if.sv
design/swz_cfg_regs.sv
design/rgba8_tile_swizzle_downscale_unit.sv
tb/testbench.sv
